>>> rtl/assert_macros.svh
// assertion macros for the rtl file that carries checks
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion failed");
// consequent must hold whenever the antecedent holds
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("implication failed");
// consequent must hold in the cycle after the antecedent holds
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/lrufr_pkg.sv
// shared constants, request codes and controller/datapath bundles
// of the lru frame replacer; no dependencies
`default_nettype none
package lrufr_pkg;

	localparam int NUM_FRAMES  = 16;
	localparam int MAX_RESULTS = 16;
	localparam int MODE_W      = 3;
	localparam int FRAME_W     = 4;
	localparam int COUNT_W     = 5;

	// request codes
	localparam logic [MODE_W-1:0] MODE_VICTIM     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PIN        = 3'd1;
	localparam logic [MODE_W-1:0] MODE_UNPIN      = 3'd2;
	localparam logic [MODE_W-1:0] MODE_UNPIN_COLD = 3'd3;
	localparam logic [MODE_W-1:0] MODE_COLD_LIST  = 3'd4;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;       // capture the incoming item
		logic look;       // evaluate the request, prime the list walk
		logic unlink;     // take the target frame out of the order
		logic link1;      // first link write and end/count update
		logic link2;      // second link write of the new frame
		logic emit_one;   // load the single result of the request
		logic emit_list;  // load one cold-list result and step the walk
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic do_unlink;
		logic do_link;
		logic list_go;
		logic list_last;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

>>> rtl/lrufr_req_if.sv
// request channel of the lru frame replacer: valid/ready plus request fields
// depends on lrufr_pkg
`default_nettype none
interface lrufr_req_if import lrufr_pkg::*;;
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [FRAME_W-1:0] frame_in;
	logic [COUNT_W-1:0] count;

	modport source (output valid, output mode, output frame_in, output count, input ready);
	modport sink (input valid, input mode, input frame_in, input count, output ready);
endinterface
`default_nettype wire

>>> rtl/lrufr_res_if.sv
// result channel of the lru frame replacer: valid/ready plus result fields
// depends on lrufr_pkg
`default_nettype none
interface lrufr_res_if import lrufr_pkg::*;;
	logic               valid;
	logic               ready;
	logic [FRAME_W-1:0] frame_out;
	logic               found;
	logic               last;
	logic [COUNT_W-1:0] evictable_count;

	modport source (output valid, output frame_out, output found, output last,
		output evictable_count, input ready);
	modport sink (input valid, input frame_out, input found, input last,
		input evictable_count, output ready);
endinterface
`default_nettype wire

>>> rtl/lrufr_ctrl.sv
// sequencing state machine of the lru frame replacer
// depends on lrufr_pkg (cmd_t, status_t)
`default_nettype none
module lrufr_ctrl import lrufr_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire status_t st,
	output cmd_t         cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_LOOK   = 3'd1;
	localparam logic [2:0] S_UNLINK = 3'd2;
	localparam logic [2:0] S_LINK1  = 3'd3;
	localparam logic [2:0] S_LINK2  = 3'd4;
	localparam logic [2:0] S_EMIT   = 3'd5;
	localparam logic [2:0] S_LIST   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// next state and command decode
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				if (st.do_unlink) begin
					state_d = S_UNLINK;
				end else if (st.do_link) begin
					state_d = S_LINK1;
				end else if (st.list_go) begin
					state_d = S_LIST;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_UNLINK: begin
				cmd.unlink = 1'b1;
				state_d    = S_EMIT;
			end
			S_LINK1: begin
				cmd.link1 = 1'b1;
				state_d   = S_LINK2;
			end
			S_LINK2: begin
				cmd.link2 = 1'b1;
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit_one = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_LIST: begin
				if (st.out_free) begin
					cmd.emit_list = 1'b1;
					if (st.list_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/lrufr_dp.sv
// datapath of the lru frame replacer: link memories, presence flags,
// list ends, frame count and the result register; depends on lrufr_pkg
`default_nettype none
module lrufr_dp import lrufr_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [MODE_W-1:0]  mode,
	input  wire logic [FRAME_W-1:0] frame_in,
	input  wire logic [COUNT_W-1:0] count,
	input  wire cmd_t               cmd,
	output status_t                 st,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [FRAME_W-1:0]      frame_out,
	output logic                    found,
	output logic                    last,
	output logic [COUNT_W-1:0]      evictable_count
);

	// link memories, no reset
	logic [FRAME_W-1:0] next_mem [NUM_FRAMES];
	logic [FRAME_W-1:0] prev_mem [NUM_FRAMES];
	logic [FRAME_W-1:0] next_rd_q;
	logic [FRAME_W-1:0] prev_rd_q;

	logic               next_we;
	logic [FRAME_W-1:0] next_wa;
	logic [FRAME_W-1:0] next_wd;
	logic               prev_we;
	logic [FRAME_W-1:0] prev_wa;
	logic [FRAME_W-1:0] prev_wd;
	logic [FRAME_W-1:0] prev_ra;

	// control state
	logic [NUM_FRAMES-1:0] flag_q;
	logic [FRAME_W-1:0]    recent_q;
	logic [FRAME_W-1:0]    cold_q;
	logic [COUNT_W-1:0]    total_q;
	logic                  out_valid_q;

	// request registers
	logic [MODE_W-1:0]  mode_q;
	logic [FRAME_W-1:0] tgt_q;
	logic [COUNT_W-1:0] count_q;
	logic               found_q;
	logic [COUNT_W-1:0] rem_q;

	// result register
	logic [FRAME_W-1:0] frame_out_q;
	logic               found_out_q;
	logic               last_q;
	logic [COUNT_W-1:0] count_out_q;

	logic               frame_ok;
	logic               flag_hit;
	logic               is_victim;
	logic               is_link;
	logic               to_cold;
	logic               at_recent;
	logic               at_cold;
	logic [COUNT_W-1:0] list_n;
	logic [COUNT_W-1:0] cap_a;
	logic               out_free;

	// request decode
	assign frame_ok  = {1'b0, tgt_q} < (FRAME_W + 1)'(NUM_FRAMES);
	assign flag_hit  = flag_q[tgt_q];
	assign is_victim = mode_q == MODE_VICTIM;
	assign is_link   = (mode_q == MODE_UNPIN) || (mode_q == MODE_UNPIN_COLD);
	assign to_cold   = mode_q == MODE_UNPIN_COLD;
	assign at_recent = recent_q == tgt_q;
	assign at_cold   = cold_q == tgt_q;

	// cold list length: smallest of count, total and the result limit
	assign cap_a  = (count_q < total_q) ? count_q : total_q;
	assign list_n = (cap_a < COUNT_W'(MAX_RESULTS)) ? cap_a : COUNT_W'(MAX_RESULTS);

	assign out_free = !out_valid_q || out_ready;

	assign st.do_unlink = (is_victim && (total_q != '0)) ||
		((mode_q == MODE_PIN) && frame_ok && flag_hit);
	assign st.do_link   = is_link && frame_ok && !flag_hit;
	assign st.list_go   = (mode_q == MODE_COLD_LIST) && (list_n != '0);
	assign st.list_last = rem_q == COUNT_W'(1);
	assign st.out_free  = out_free;

	// link write selection
	always_comb begin
		next_we = 1'b0;
		next_wa = tgt_q;
		next_wd = tgt_q;
		prev_we = 1'b0;
		prev_wa = tgt_q;
		prev_wd = tgt_q;
		if (cmd.unlink) begin
			if (at_recent && at_cold) begin
				next_we = 1'b0;
			end else if (at_recent) begin
				prev_we = 1'b1;
				prev_wa = next_rd_q;
				prev_wd = next_rd_q;
			end else if (at_cold) begin
				next_we = 1'b1;
				next_wa = prev_rd_q;
				next_wd = prev_rd_q;
			end else begin
				next_we = 1'b1;
				next_wa = prev_rd_q;
				next_wd = next_rd_q;
				prev_we = 1'b1;
				prev_wa = next_rd_q;
				prev_wd = prev_rd_q;
			end
		end else if (cmd.link1) begin
			if (total_q == '0) begin
				next_we = 1'b1;
				prev_we = 1'b1;
			end else if (to_cold) begin
				next_we = 1'b1;
				next_wa = cold_q;
				next_wd = tgt_q;
				prev_we = 1'b1;
				prev_wd = cold_q;
			end else begin
				prev_we = 1'b1;
				prev_wa = recent_q;
				prev_wd = tgt_q;
				next_we = 1'b1;
				next_wd = recent_q;
			end
		end else if (cmd.link2) begin
			// the new frame points at itself on its open side
			next_we = to_cold;
			prev_we = !to_cold;
		end
	end

	// the walk reads ahead from the fetched link while it emits
	assign prev_ra = cmd.emit_list ? prev_rd_q : tgt_q;

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		next_rd_q <= next_mem[tgt_q];
	end

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		prev_rd_q <= prev_mem[prev_ra];
	end

	// order state: flags, ends, count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q   <= '0;
			recent_q <= '0;
			cold_q   <= '0;
			total_q  <= '0;
		end else if (cmd.unlink) begin
			if (at_recent && at_cold) begin
				recent_q <= '0;
				cold_q   <= '0;
			end else if (at_recent) begin
				recent_q <= next_rd_q;
			end else if (at_cold) begin
				cold_q <= prev_rd_q;
			end
			flag_q[tgt_q] <= 1'b0;
			if (total_q != '0) begin
				total_q <= total_q - COUNT_W'(1);
			end
		end else if (cmd.link1) begin
			if (total_q == '0) begin
				recent_q <= tgt_q;
				cold_q   <= tgt_q;
			end else if (to_cold) begin
				cold_q <= tgt_q;
			end else begin
				recent_q <= tgt_q;
			end
			flag_q[tgt_q] <= 1'b1;
			total_q       <= total_q + COUNT_W'(1);
		end
	end

	// request capture; victim and cold list start at the cold end
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			count_q <= count;
			if ((mode == MODE_VICTIM) || (mode == MODE_COLD_LIST)) begin
				tgt_q <= cold_q;
			end else begin
				tgt_q <= frame_in;
			end
		end else if (cmd.emit_list) begin
			tgt_q <= prev_rd_q;
		end
		if (cmd.look) begin
			found_q <= is_victim && (total_q != '0);
			rem_q   <= list_n;
		end else if (cmd.emit_list) begin
			rem_q <= rem_q - COUNT_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_one || cmd.emit_list) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_one) begin
			frame_out_q <= found_q ? tgt_q : '0;
			found_out_q <= found_q;
			last_q      <= 1'b1;
			count_out_q <= total_q;
		end else if (cmd.emit_list) begin
			frame_out_q <= tgt_q;
			found_out_q <= 1'b1;
			last_q      <= rem_q == COUNT_W'(1);
			count_out_q <= total_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign frame_out       = frame_out_q;
	assign found           = found_out_q;
	assign last            = last_q;
	assign evictable_count = count_out_q;

endmodule
`default_nettype wire

>>> rtl/lru_frame_replacer.sv
// top level of the lru frame replacer: controller plus datapath
// depends on lrufr_pkg, lrufr_req_if, lrufr_res_if, lrufr_ctrl, lrufr_dp
//
// Usage:
//   req carries one request per item (mode, frame_in, count); res returns
//   the results (frame_out, found, last, evictable_count), last marking the
//   final result of a request. Both are valid/ready channels.
//   One request is worked on at a time; req.ready is high only while the
//   block is between requests. An accepted request is captured and
//   evaluated; a victim or pin then unlinks its frame, an unpin or
//   unpin-cold links it in a first and a second link write since each link
//   table has one write port, and a request that changes nothing goes
//   straight to its result. A cold list walks the previous-link table one
//   frame per cycle while the output is free. Idle lies between requests.
//   The last result waits in an output register; while res.ready is low the
//   walk holds its place and nothing is lost or repeated.
//   Reset clears the presence flags, the list ends, the frame count and the
//   output valid; the link tables are not cleared and need no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module lru_frame_replacer import lrufr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	lrufr_req_if.sink req,
	lrufr_res_if.source res
);

	cmd_t    cmd;
	status_t st;
	logic    ready;

	lrufr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (ready),
		.st       (st),
		.cmd      (cmd)
	);

	lrufr_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.mode            (req.mode),
		.frame_in        (req.frame_in),
		.count           (req.count),
		.cmd             (cmd),
		.st              (st),
		.out_valid       (res.valid),
		.out_ready       (res.ready),
		.frame_out       (res.frame_out),
		.found           (res.found),
		.last            (res.last),
		.evictable_count (res.evictable_count)
	);

	assign req.ready = ready;

	// checks
	`ASSERT_IMP(a_count_range, clk, arst_n, res.valid,
		res.evictable_count <= COUNT_W'(NUM_FRAMES))
	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, req.valid && ready, !ready)
	`ASSERT_IMP(a_empty_is_last, clk, arst_n, res.valid && !res.found, res.last)
	`ASSERT_IMP(a_empty_frame_zero, clk, arst_n, res.valid && !res.found,
		res.frame_out == '0)
	`ASSERT_IMP(a_emit_needs_room, clk, arst_n, cmd.emit_one || cmd.emit_list,
		st.out_free)

endmodule
`default_nettype wire
